FILE: rtl/core/first_fit_block_allocator_unit_assert.svh
// assertion macros for the first-fit block allocator
// included by the top level; no other dependencies
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define FFBA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffba assertion failed");
// antecedent implies consequent in the next cycle
`define FFBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffba assertion failed");
// property holds at every edge
`define FFBA_ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ffba assertion failed");
`else
`define FFBA_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define FFBA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define FFBA_ASSERT_ALWAYS(lbl, clk, rst, prop)
`endif

`endif

FILE: rtl/core/ffba_pkg.sv
// shared types and constants of the first-fit block allocator
// no dependencies
package ffba_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int ADDR_BITS_DEF    = 20;
  localparam int HEAP_LIMIT_RST   = 1048575;
  localparam int HDR_W            = 7;
  localparam int HEADER_BYTES_RST = 24;
  localparam int STATUS_W         = 3;
  localparam int PADDR_W          = 3;
  localparam int PDATA_W          = 32;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_NULL    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic {
    REG_HEAP_LIMIT   = 1'b0,
    REG_HEADER_BYTES = 1'b1
  } reg_idx_t;

endpackage

FILE: rtl/core/ffba_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/ffba_cfg.sv
// apb register file: heap limit and header size
// depends on ffba_pkg
module ffba_cfg #(
  parameter int ADDR_BITS = ffba_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ffba_pkg::PADDR_W-1:0]     paddr,
  input  logic [ffba_pkg::PDATA_W-1:0]     pwdata,
  output logic [ffba_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  output logic [ADDR_BITS-1:0]             heap_limit,
  output logic [ffba_pkg::HDR_W-1:0]       header_bytes
);

  ffba_pkg::reg_idx_t reg_idx;
  logic               wr_hit;

  assign reg_idx = ffba_pkg::reg_idx_t'(paddr[2]);
  assign wr_hit  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit   <= ADDR_BITS'(ffba_pkg::HEAP_LIMIT_RST);
      header_bytes <= ffba_pkg::HDR_W'(ffba_pkg::HEADER_BYTES_RST);
    end else if (wr_hit) begin
      case (reg_idx)
        ffba_pkg::REG_HEAP_LIMIT:   heap_limit   <= pwdata[ADDR_BITS-1:0];
        ffba_pkg::REG_HEADER_BYTES: header_bytes <= pwdata[ffba_pkg::HDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ffba_pkg::REG_HEAP_LIMIT:   prdata = ffba_pkg::PDATA_W'(heap_limit);
      ffba_pkg::REG_HEADER_BYTES: prdata = ffba_pkg::PDATA_W'(header_bytes);
      default:                    prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/ffba_engine.sv
// request sequencer: scans the block table in ram, grants, frees, appends
// depends on ffba_pkg; drives the block table ram ports
module ffba_engine #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_BITS  = ffba_pkg::ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic [ADDR_BITS-1:0]                req_size,
  input  logic [ADDR_BITS-1:0]                free_addr,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ADDR_BITS-1:0]                resp_addr,
  output logic [ffba_pkg::STATUS_W-1:0]       resp_status,
  input  logic [ADDR_BITS-1:0]                heap_limit,
  input  logic [ffba_pkg::HDR_W-1:0]          header_bytes,
  output logic                                mem_rd_en,
  output logic [$clog2(MAX_BLOCKS)-1:0]       mem_rd_addr,
  input  logic [2*ADDR_BITS:0]                mem_rd_data,
  output logic                                mem_wr_en,
  output logic [$clog2(MAX_BLOCKS)-1:0]       mem_wr_addr,
  output logic [2*ADDR_BITS:0]                mem_wr_data,
  output logic [$clog2(MAX_BLOCKS):0]         blk_count
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = IDX_W + 1;
  localparam int TOP_W = ADDR_BITS + 2;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESP} state_t;

  state_t                 state;
  logic                   op_free;
  logic [ADDR_BITS-1:0]   op_size;
  logic [ADDR_BITS-1:0]   op_addr;
  logic [CNT_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       chk_idx;
  logic                   chk_valid;
  logic [ADDR_BITS:0]     heap_top;
  logic [ADDR_BITS-1:0]   res_addr;
  ffba_pkg::status_t      res_status;

  logic [ADDR_BITS-1:0]   ent_start;
  logic [ADDR_BITS-1:0]   ent_bytes;
  logic                   ent_free;
  logic [ADDR_BITS-1:0]   ent_payload;
  logic                   ent_hit;
  logic                   more;
  logic                   scan_hit;
  logic                   scan_miss;
  logic                   table_full;
  logic [TOP_W-1:0]       new_top;
  logic                   fits;
  logic                   append;
  logic [ADDR_BITS-1:0]   top_payload;

  assign ent_start   = mem_rd_data[2*ADDR_BITS -: ADDR_BITS];
  assign ent_bytes   = mem_rd_data[ADDR_BITS:1];
  assign ent_free    = mem_rd_data[0];
  assign ent_payload = ent_start + ADDR_BITS'(header_bytes);
  assign ent_hit     = op_free ? (ent_payload == op_addr)
                               : (ent_free && (ent_bytes >= op_size));

  assign more       = rd_idx < blk_count;
  assign scan_hit   = (state == S_SCAN) && chk_valid && ent_hit;
  // last read came back without a hit and nothing is left to read
  assign scan_miss  = (state == S_SCAN) && !chk_valid && !more;
  assign table_full = blk_count == CNT_W'(MAX_BLOCKS);
  assign new_top    = TOP_W'(heap_top) + TOP_W'(header_bytes) + TOP_W'(op_size);
  assign fits       = new_top <= TOP_W'(heap_limit);
  assign append     = scan_miss && !op_free && !table_full && fits;
  assign top_payload = heap_top[ADDR_BITS-1:0] + ADDR_BITS'(header_bytes);

  assign in_ready    = state == S_IDLE;
  assign mem_rd_en   = (state == S_SCAN) && more;
  assign mem_rd_addr = rd_idx[IDX_W-1:0];
  assign mem_wr_en   = scan_hit || append;
  assign mem_wr_addr = scan_hit ? chk_idx : blk_count[IDX_W-1:0];
  assign mem_wr_data = scan_hit ? {ent_start, ent_bytes, op_free}
                                : {heap_top[ADDR_BITS-1:0], op_size, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      chk_valid <= 1'b0;
      blk_count <= '0;
      heap_top  <= '0;
    end else begin
      // output register loads from the response state, else drains on a taken beat
      if ((state == S_RESP) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_free   <= req_type == ffba_pkg::REQ_FREE;
            op_size   <= req_size;
            op_addr   <= free_addr;
            rd_idx    <= '0;
            chk_valid <= 1'b0;
            res_addr  <= '0;
            if ((req_type == ffba_pkg::REQ_ALLOC) && (req_size == '0)) begin
              res_status <= ffba_pkg::ST_ZERO;
              state      <= S_RESP;
            end else if ((req_type == ffba_pkg::REQ_FREE) && (free_addr == '0)) begin
              res_status <= ffba_pkg::ST_NULL;
              state      <= S_RESP;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          chk_valid <= mem_rd_en;
          chk_idx   <= rd_idx[IDX_W-1:0];
          if (mem_rd_en) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (scan_hit) begin
            res_addr   <= op_free ? '0 : ent_payload;
            res_status <= ffba_pkg::ST_OK;
            state      <= S_RESP;
          end else if (scan_miss) begin
            if (op_free) begin
              res_status <= ffba_pkg::ST_UNKNOWN;
            end else if (append) begin
              res_addr   <= top_payload;
              res_status <= ffba_pkg::ST_OK;
              blk_count  <= blk_count + 1'b1;
              heap_top   <= new_top[ADDR_BITS:0];
            end else begin
              res_status <= ffba_pkg::ST_NOSPACE;
            end
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            resp_addr   <= res_addr;
            resp_status <= res_status;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/first_fit_block_allocator_unit.sv
// top level of the first-fit block allocator
// depends on ffba_pkg, ffba_cfg, ffba_engine, ffba_ram and the assertion header
//
// request channel (in_valid/in_ready): one beat carries req_type, req_size and
// free_addr. an allocate reuses the first free block that is large enough, or
// appends one at the heap top if heap_limit and the table size allow; a free
// marks the block whose payload address (start + header_bytes) matches.
// response channel (out_valid/out_ready): one beat per request, resp_addr and
// resp_status, held in an output register.
// config port: apb writes to heap_limit (offset 0) and header_bytes (offset 4),
// pready tied high; write only while no request is in flight.
// timing: the table sits in one ram with a registered read, scanned one entry
// per cycle. zero-size allocates and null frees skip the scan. one request is
// in work at a time; the next is accepted only once the response is registered
// and the engine is back in idle.
// reset: sync rst empties the table and loads register defaults; ram left as is
// stalls: with out_ready low the held beat waits; one more request can finish
// behind it, then no request is accepted until the output register frees up.
`include "first_fit_block_allocator_unit_assert.svh"

module first_fit_block_allocator_unit #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_BITS  = ffba_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [ADDR_BITS-1:0]            req_size,
  input  logic [ADDR_BITS-1:0]            free_addr,
  // response channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ADDR_BITS-1:0]            resp_addr,
  output logic [ffba_pkg::STATUS_W-1:0]   resp_status,
  // config port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ffba_pkg::PADDR_W-1:0]    paddr,
  input  logic [ffba_pkg::PDATA_W-1:0]    pwdata,
  output logic [ffba_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  // one table entry: {start, bytes, free mark}
  localparam int ENT_W = 2 * ADDR_BITS + 1;

  logic [ADDR_BITS-1:0]        heap_limit;
  logic [ffba_pkg::HDR_W-1:0]  header_bytes;

  logic                        mem_rd_en;
  logic [IDX_W-1:0]            mem_rd_addr;
  logic [ENT_W-1:0]            mem_rd_data;
  logic                        mem_wr_en;
  logic [IDX_W-1:0]            mem_wr_addr;
  logic [ENT_W-1:0]            mem_wr_data;
  logic [IDX_W:0]              blk_count;

  // register file
  ffba_cfg #(
    .ADDR_BITS (ADDR_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .heap_limit   (heap_limit),
    .header_bytes (header_bytes)
  );

  // scan / grant / append sequencer
  ffba_engine #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .req_size     (req_size),
    .free_addr    (free_addr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .resp_addr    (resp_addr),
    .resp_status  (resp_status),
    .heap_limit   (heap_limit),
    .header_bytes (header_bytes),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .blk_count    (blk_count)
  );

  // block table; a write and the next request's first read never share a
  // cycle because the response state sits between them
  ffba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // table never grows past its capacity
  `FFBA_ASSERT_ALWAYS(a_count_bound, clk, rst, blk_count <= (IDX_W+1)'(MAX_BLOCKS))

  // the engine is busy in the cycle after it accepts a request
  `FFBA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // every failed response carries a null address
  `FFBA_ASSERT_IMPLY(a_fail_null_addr, clk, rst,
    out_valid && (resp_status != ffba_pkg::ST_OK), resp_addr == '0)

  // the table is written only while a request is being served
  `FFBA_ASSERT_IMPLY(a_write_when_busy, clk, rst, mem_wr_en, !in_ready && !mem_rd_en || !in_ready)

endmodule
